FILE: design/qft_pkg.sv
// ----------------------------------------------------------------------------
// qft_pkg
// Types and character constants shared by the quoted field tokenizer.
// ----------------------------------------------------------------------------
package qft_pkg;

    // Characters with a meaning to the tokenizer
    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_TAB    = 8'h09;
    localparam logic [7:0] CHAR_QUOTE  = 8'h22;
    localparam logic [7:0] CHAR_HASH   = 8'h23;
    localparam logic [7:0] CHAR_BSLASH = 8'h5C;

    // Result kinds
    localparam logic [1:0] KIND_BYTE    = 2'd0;
    localparam logic [1:0] KIND_END     = 2'd1;
    localparam logic [1:0] KIND_VERDICT = 2'd2;

    // Line verdicts
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_COUNT = 2'd2;

    // Configuration register indexes
    localparam logic CFG_FIELD_COUNT = 1'b0;
    localparam logic CFG_ALLOW_EXTRA = 1'b1;

    // Result queue geometry
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;
    localparam int QUEUE_CW    = 3;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       line_end;
    } item_t;

    typedef struct packed {
        logic [1:0] result_kind;
        logic [7:0] token_byte;
        logic [1:0] line_status;
        logic [7:0] tokens_in_line;
        logic       last_result;
    } result_t;

endpackage

FILE: design/quoted_field_tokenizer.sv
// ----------------------------------------------------------------------------
// quoted_field_tokenizer
// Splits a byte stream into blank-separated, quote- and escape-aware tokens.
// ----------------------------------------------------------------------------
// Usage:
//   item channel (item_valid/item_ready/item): one text byte per transfer, or
//   an end-of-line marker with item.line_end set.
//   result channel (result_valid/result_ready/result): token bytes, token end
//   marks and one verdict per line; last_result flags the final result that
//   a given item caused.
//   cfg_write/cfg_index/cfg_data set field_count (index 0) and allow_extra
//   (index 1); write them only while the block is idle.
// Timing:
//   An accepted item is decoded in the same cycle against the line state and
//   its results are written into a four-entry result queue, which feeds the
//   result port. One item is taken every cycle while item_ready is high. An end
//   of line that closes a token makes two results, so the queue drains one
//   result behind; item_ready drops while fewer than two queue slots are free.
// Reset:
//   Line state clears, the queue empties, field_count is 1, allow_extra is 0.
//   A stalled result receiver fills the queue and then holds item_ready low.
// ----------------------------------------------------------------------------
module quoted_field_tokenizer
    import qft_pkg::*;
#(
    parameter int MAX_TOKENS = 255
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_ready,
    input  item_t      item,
    output logic       result_valid,
    input  logic       result_ready,
    output result_t    result,
    input  logic       cfg_write,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data
);

    localparam int         CAP_INT   = (MAX_TOKENS < 255) ? MAX_TOKENS : 255;
    localparam logic [7:0] COUNT_CAP = CAP_INT[7:0];

    // Configuration
    logic [7:0] field_count_reg;
    logic       allow_extra_reg;

    // Line state
    logic       in_quotes_reg,  in_quotes_next;
    logic       tok_open_reg,   tok_open_next;
    logic       escape_reg,     escape_next;
    logic       in_comment_reg, in_comment_next;
    logic       has_bytes_reg,  has_bytes_next;
    logic [7:0] tok_cnt_reg,    tok_cnt_next;

    // Result queue
    result_t             queue_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CW-1:0] count_reg,  count_next;

    logic       accept;
    logic       pop;
    logic [1:0] push_n;
    result_t    res0;
    result_t    res1;
    result_t    verdict;
    logic       blank;
    logic [7:0] cnt_closed;

    assign accept       = item_valid && item_ready;
    assign pop          = result_valid && result_ready;
    assign item_ready   = (count_reg <= QUEUE_CW'(QUEUE_DEPTH - 2));
    assign result_valid = (count_reg != '0);
    assign result       = queue_mem[rd_ptr_reg];

    assign blank = (item.text_byte == CHAR_SPACE) || (item.text_byte == CHAR_TAB);

    // Count after closing the final token of the line, if it holds bytes
    assign cnt_closed = (has_bytes_reg && (tok_cnt_reg < COUNT_CAP))
                        ? tok_cnt_reg + 8'd1 : tok_cnt_reg;

    always_comb
    begin
        verdict                = '0;
        verdict.result_kind    = KIND_VERDICT;
        verdict.tokens_in_line = cnt_closed;
        verdict.last_result    = 1'b1;
        if ((cnt_closed == field_count_reg) ||
            (allow_extra_reg && (cnt_closed > field_count_reg)))
            verdict.line_status = STATUS_OK;
        else if (cnt_closed != 8'd0)
            verdict.line_status = STATUS_COUNT;
        else
            verdict.line_status = STATUS_EMPTY;
    end

    always_comb
    begin
        in_quotes_next  = in_quotes_reg;
        tok_open_next   = tok_open_reg;
        escape_next     = escape_reg;
        in_comment_next = in_comment_reg;
        has_bytes_next  = has_bytes_reg;
        tok_cnt_next    = tok_cnt_reg;
        res0            = '0;
        res1            = '0;
        push_n          = 2'd0;

        if (item.line_end)
        begin
            // Close a nonempty token, then give the verdict and clear the line
            if (has_bytes_reg)
            begin
                res0.result_kind = KIND_END;
                res1             = verdict;
                push_n           = 2'd2;
            end
            else
            begin
                res0   = verdict;
                push_n = 2'd1;
            end
            in_quotes_next  = 1'b0;
            tok_open_next   = 1'b0;
            escape_next     = 1'b0;
            in_comment_next = 1'b0;
            has_bytes_next  = 1'b0;
            tok_cnt_next    = 8'd0;
        end
        else if (!in_comment_reg)
        begin
            if (escape_reg)
            begin
                // Escaped byte joins the token but does not open one
                res0.result_kind = KIND_BYTE;
                res0.token_byte  = item.text_byte;
                res0.last_result = 1'b1;
                push_n           = 2'd1;
                has_bytes_next   = 1'b1;
                escape_next      = 1'b0;
            end
            else if (((!in_quotes_reg && blank) ||
                      (in_quotes_reg && (item.text_byte == CHAR_QUOTE))) && tok_open_reg)
            begin
                res0.result_kind = KIND_END;
                res0.last_result = 1'b1;
                push_n           = 2'd1;
                if (tok_cnt_reg < COUNT_CAP)
                    tok_cnt_next = tok_cnt_reg + 8'd1;
                in_quotes_next = 1'b0;
                tok_open_next  = 1'b0;
                has_bytes_next = 1'b0;
            end
            else if (item.text_byte == CHAR_QUOTE)
            begin
                tok_open_next  = 1'b1;
                in_quotes_next = 1'b1;
            end
            else if (!in_quotes_reg && (item.text_byte == CHAR_HASH))
            begin
                in_comment_next = 1'b1;
            end
            else if (item.text_byte == CHAR_BSLASH)
            begin
                escape_next = 1'b1;
            end
            else if (in_quotes_reg || !blank)
            begin
                tok_open_next    = 1'b1;
                res0.result_kind = KIND_BYTE;
                res0.token_byte  = item.text_byte;
                res0.last_result = 1'b1;
                push_n           = 2'd1;
                has_bytes_next   = 1'b1;
            end
        end
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (accept)
        begin
            wr_ptr_next = wr_ptr_reg + QUEUE_AW'(push_n);
            count_next  = count_reg + QUEUE_CW'(push_n);
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + QUEUE_AW'(1);
            count_next  = count_next - QUEUE_CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_count_reg <= 8'd1;
            allow_extra_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_FIELD_COUNT: field_count_reg <= cfg_data;
                CFG_ALLOW_EXTRA: allow_extra_reg <= cfg_data[0];
                default:         field_count_reg <= field_count_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_quotes_reg  <= 1'b0;
            tok_open_reg   <= 1'b0;
            escape_reg     <= 1'b0;
            in_comment_reg <= 1'b0;
            has_bytes_reg  <= 1'b0;
            tok_cnt_reg    <= 8'd0;
        end
        else if (accept)
        begin
            in_quotes_reg  <= in_quotes_next;
            tok_open_reg   <= tok_open_next;
            escape_reg     <= escape_next;
            in_comment_reg <= in_comment_next;
            has_bytes_reg  <= has_bytes_next;
            tok_cnt_reg    <= tok_cnt_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (push_n != 2'd0))
            queue_mem[wr_ptr_reg] <= res0;
        if (accept && (push_n == 2'd2))
            queue_mem[wr_ptr_reg + QUEUE_AW'(1)] <= res1;
    end

`ifndef NO_ASSERTIONS
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QUEUE_CW'(QUEUE_DEPTH))
        else $error("result queue overfilled");

    a_verdict_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.result_kind == KIND_VERDICT) |-> result.last_result)
        else $error("line verdict not flagged as last result");

    a_line_clear: assert property (@(posedge clk) disable iff (!rst_n)
        accept && item.line_end |=> (tok_cnt_reg == 8'd0) && !in_quotes_reg
                                    && !in_comment_reg && !escape_reg)
        else $error("line state not cleared after end of line");

    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.result_kind == KIND_VERDICT)
        |-> (result.tokens_in_line <= COUNT_CAP))
        else $error("token count above saturation cap");
`endif

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the quoted field tokenizer. Text bytes and line ends
// go in through a valid/ready channel, and an in-bench line parser predicts
// the token bytes, token end marks and line verdicts. Every result transfer is
// compared field by field against the oldest prediction. Stimulus runs short
// directed lines, field count settings, count saturation and random lines
// under three sender/receiver idle mixes.
// ----------------------------------------------------------------------------
module tb_top;
    import qft_pkg::*;

    localparam int TOKEN_LIMIT  = 255;
    localparam int COUNT_CAP    = (TOKEN_LIMIT < 255) ? TOKEN_LIMIT : 255;
    localparam int STALL_LIMIT  = 4000;
    localparam int PHASE_ITEMS  = 240;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       item_valid;
    logic       item_ready;
    item_t      item;
    logic       result_valid;
    logic       result_ready;
    result_t    result;
    logic       cfg_write;
    logic       cfg_index;
    logic [7:0] cfg_data;

    // Line parser state and its copy of the registers
    logic       quoting;
    logic       tok_open;
    logic       escaping;
    logic       commenting;
    logic       tok_filled;
    logic [7:0] tok_total;
    logic [7:0] want_fields;
    logic       extra_ok;

    result_t    line_results_q [$];
    int         mismatches;
    int         items_sent;
    int         send_idle_pct;
    int         recv_idle_pct;
    int         quiet_cycles;

    quoted_field_tokenizer #(
        .MAX_TOKENS (TOKEN_LIMIT)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------
    function automatic void tokenize_char(item_t it);
        result_t    outs [2];
        int         n;
        logic       blank;
        logic [7:0] c;
        n       = 0;
        c       = it.text_byte;
        blank   = (c == CHAR_SPACE) || (c == CHAR_TAB);
        outs[0] = '0;
        outs[1] = '0;
        if (it.line_end)
        begin
            // Close a token only if it holds bytes; drop pending escape
            if (tok_filled)
            begin
                outs[n].result_kind = KIND_END;
                n++;
                if (tok_total < COUNT_CAP)
                    tok_total++;
            end
            outs[n].result_kind    = KIND_VERDICT;
            outs[n].tokens_in_line = tok_total;
            if (tok_total == want_fields || (extra_ok && tok_total > want_fields))
                outs[n].line_status = STATUS_OK;
            else if (tok_total != 0)
                outs[n].line_status = STATUS_COUNT;
            else
                outs[n].line_status = STATUS_EMPTY;
            n++;
            quoting    = 1'b0;
            tok_open   = 1'b0;
            escaping   = 1'b0;
            commenting = 1'b0;
            tok_filled = 1'b0;
            tok_total  = '0;
        end
        else if (!commenting)
        begin
            if (escaping)
            begin
                // Escaped byte joins the token but does not open one
                outs[n].result_kind = KIND_BYTE;
                outs[n].token_byte  = c;
                n++;
                tok_filled = 1'b1;
                escaping   = 1'b0;
            end
            else if (((!quoting && blank) || (quoting && c == CHAR_QUOTE)) && tok_open)
            begin
                outs[n].result_kind = KIND_END;
                n++;
                if (tok_total < COUNT_CAP)
                    tok_total++;
                quoting    = 1'b0;
                tok_open   = 1'b0;
                tok_filled = 1'b0;
            end
            else if (c == CHAR_QUOTE)
            begin
                tok_open = 1'b1;
                quoting  = 1'b1;
            end
            else if (!quoting && c == CHAR_HASH)
                commenting = 1'b1;
            else if (c == CHAR_BSLASH)
                escaping = 1'b1;
            else if (quoting || !blank)
            begin
                tok_open            = 1'b1;
                outs[n].result_kind = KIND_BYTE;
                outs[n].token_byte  = c;
                n++;
                tok_filled = 1'b1;
            end
        end
        for (int i = 0; i < n; i++)
        begin
            outs[i].last_result = (i == n - 1);
            line_results_q = {line_results_q, outs[i]};
        end
    endfunction

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("%0t: %s: got %0h, want %0h", $time, what, got, want);
        mismatches++;
    endtask

    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (line_results_q.size() == 0)
                report_mismatch("result with nothing awaited", 8'(result.result_kind),
                                8'd0);
            else
            begin
                want = line_results_q.pop_front();
                if (result.result_kind !== want.result_kind)
                    report_mismatch("result_kind", 8'(result.result_kind),
                                    8'(want.result_kind));
                if (result.token_byte !== want.token_byte)
                    report_mismatch("token_byte", result.token_byte, want.token_byte);
                if (result.line_status !== want.line_status)
                    report_mismatch("line_status", 8'(result.line_status),
                                    8'(want.line_status));
                if (result.tokens_in_line !== want.tokens_in_line)
                    report_mismatch("tokens_in_line", result.tokens_in_line,
                                    want.tokens_in_line);
                if (result.last_result !== want.last_result)
                    report_mismatch("last_result", 8'(result.last_result),
                                    8'(want.last_result));
            end
        end
    end

    // Receiver stalls at random
    always @(negedge clk)
        result_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && item_ready) || (result_valid && result_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------------
    task automatic send_item(input logic [7:0] b, input logic eol);
        item_t it;
        it = '{text_byte: b, line_end: eol};
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        do
            @(posedge clk);
        while (!item_ready);
        tokenize_char(it);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_item(s[i], 1'b0);
    endtask

    task automatic end_line();
        send_item(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // Hold the sender until every predicted result has come out
    task automatic hold_until_drained();
        item_valid <= 1'b0;
        @(negedge clk);
        while (line_results_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic configure(input logic [7:0] fields, input logic extra);
        hold_until_drained();
        // Let a trailing item that makes no result clear the pipeline
        repeat (4) @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= CFG_FIELD_COUNT;
        cfg_data  <= fields;
        @(negedge clk);
        cfg_index <= CFG_ALLOW_EXTRA;
        cfg_data  <= {7'd0, extra};
        @(negedge clk);
        cfg_write   <= 1'b0;
        want_fields  = fields;
        extra_ok     = extra;
    endtask

    function automatic logic [7:0] word_char();
        logic [7:0] ch;
        do
            ch = 8'($urandom_range(8'h21, 8'hFF));
        while (ch == CHAR_QUOTE || ch == CHAR_HASH || ch == CHAR_BSLASH);
        return ch;
    endfunction

    function automatic logic [7:0] blank_char();
        return $urandom_range(0, 1) ? CHAR_SPACE : CHAR_TAB;
    endfunction

    task automatic send_random_line();
        int n_tok;
        int kind;
        int len;
        n_tok = $urandom_range(0, 6);
        for (int t = 0; t < n_tok; t++)
        begin
            repeat ((t == 0) ? $urandom_range(0, 1) : $urandom_range(1, 2))
                send_item(blank_char(), 1'b0);
            kind = $urandom_range(0, 9);
            len  = $urandom_range(1, 5);
            case (kind)
                0, 1, 2, 3, 4:
                    repeat (len) send_item(word_char(), 1'b0);
                5, 6:
                begin
                    send_item(CHAR_QUOTE, 1'b0);
                    repeat (len)
                    begin
                        case ($urandom_range(0, 4))
                            0: send_item(blank_char(), 1'b0);
                            1: send_item(CHAR_HASH, 1'b0);
                            2:
                            begin
                                send_item(CHAR_BSLASH, 1'b0);
                                send_item(8'($urandom_range(0, 255)), 1'b0);
                            end
                            default: send_item(word_char(), 1'b0);
                        endcase
                    end
                    send_item(CHAR_QUOTE, 1'b0);
                end
                7:
                begin
                    repeat (len)
                    begin
                        if ($urandom_range(0, 1))
                        begin
                            send_item(CHAR_BSLASH, 1'b0);
                            send_item(8'($urandom_range(0, 255)), 1'b0);
                        end
                        else
                            send_item(word_char(), 1'b0);
                    end
                end
                8:
                    repeat (len) send_item(8'($urandom_range(0, 255)), 1'b0);
                default:
                begin
                    send_item(CHAR_QUOTE, 1'b0);
                    send_item(CHAR_QUOTE, 1'b0);
                end
            endcase
        end
        // Tail: comment, unterminated quote, dangling escape or stray blank
        case ($urandom_range(0, 9))
            0, 1:
            begin
                send_item(blank_char(), 1'b0);
                send_item(CHAR_HASH, 1'b0);
                repeat ($urandom_range(0, 4))
                    send_item(8'($urandom_range(0, 255)), 1'b0);
            end
            2:
            begin
                send_item(CHAR_QUOTE, 1'b0);
                send_item(word_char(), 1'b0);
            end
            3: send_item(CHAR_BSLASH, 1'b0);
            4: send_item(blank_char(), 1'b0);
            default: ;
        endcase
        end_line();
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_directed_lines();
        // Tab split, quoted token with a blank, two tokens against one field
        send_text("a\t\"x y\"");
        end_line();
        // Extreme bytes, escaped quote, comment swallows the rest
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_text("\\\"#z");
        send_item(8'hFF, 1'b1);
        // Leading blank, escaped backslash, escape dropped at line end
        send_text(" \\\\\\");
        send_item(8'h00, 1'b1);
        // Quote left open with no bytes: empty line
        send_text("\"");
        end_line();
        // Escaped blank does not open a token, escaped hash is data
        send_text("\\ x \\#");
        end_line();
    endtask

    task automatic test_field_settings();
        configure(8'd0, 1'b0);
        end_line();
        send_text("q");
        end_line();
        configure(8'd255, 1'b1);
        send_text("a b");
        end_line();
        configure(8'd2, 1'b1);
        send_text("a b c");
        end_line();
        send_text("a");
        end_line();
        configure(8'd3, 1'b0);
        send_text("a b c d");
        end_line();
        send_text("x\ty z");
        end_line();
        configure(8'($urandom_range(0, 255)), 1'b1);
        send_random_line();
    endtask

    task automatic test_count_saturation();
        configure(8'd255, 1'b0);
        repeat (258)
        begin
            send_item(word_char(), 1'b0);
            send_item(blank_char(), 1'b0);
        end
        end_line();
        configure(8'd254, 1'b0);
        repeat (257)
        begin
            send_item(word_char(), 1'b0);
            send_item(CHAR_SPACE, 1'b0);
        end
        end_line();
    endtask

    task automatic test_random_traffic(input int sender_pct, input int receiver_pct);
        int goal;
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        for (int chunk = 0; chunk < 3; chunk++)
        begin
            configure(8'($urandom_range(0, 5)), 1'($urandom_range(0, 1)));
            goal = items_sent + PHASE_ITEMS / 3;
            send_random_line();
            hold_until_drained();
            while (items_sent < goal)
            begin
                send_random_line();
                if ($urandom_range(0, 7) == 0)
                    hold_until_drained();
            end
        end
    endtask

    initial
    begin
        item_valid    = 1'b0;
        item          = '0;
        result_ready  = 1'b0;
        cfg_write     = 1'b0;
        cfg_index     = CFG_FIELD_COUNT;
        cfg_data      = '0;
        rst_n         = 1'b0;
        mismatches    = 0;
        items_sent    = 0;
        quiet_cycles  = 0;
        send_idle_pct = 25;
        recv_idle_pct = 84;
        quoting       = 1'b0;
        tok_open      = 1'b0;
        escaping      = 1'b0;
        commenting    = 1'b0;
        tok_filled    = 1'b0;
        tok_total     = '0;
        want_fields   = 8'd1;
        extra_ok      = 1'b0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed_lines();
        test_field_settings();
        test_count_saturation();
        test_random_traffic(25, 84);
        test_random_traffic(84, 25);
        test_random_traffic(0, 0);

        hold_until_drained();
        repeat (8) @(negedge clk);
        if (line_results_q.size() != 0)
            report_mismatch("results never delivered", 8'(line_results_q.size()), 8'd0);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: files.f
design/qft_pkg.sv
design/quoted_field_tokenizer.sv
tb/tb_top.sv
